### hw/rtl/asspd_pkg.sv
`default_nettype none

package asspd_pkg;

  localparam int NUM_ACTUATORS_DEF = 5;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NOP   = 2'd3;

  localparam logic [6:0] POS_ACTUATOR  = 7'd1;
  localparam logic [6:0] POS_DIRECTION = 7'd2;
  localparam logic [6:0] POS_COUNT     = 7'd3;
  localparam logic [6:0] POS_PERIOD    = 7'd4;

  localparam logic [4:0] ALL_OFF = 5'h1F;
  localparam logic [7:0] DIR_IN1 = 8'd1;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] byte_pos;
    logic [7:0] data;
  } in_word_t;

  typedef struct packed {
    logic [4:0] enable_lines;
    logic       step_level;
    logic       dc_in1;
    logic       dc_in2;
    logic [7:0] read_data;
    logic       busy_res;
    logic       error;
  } out_word_t;

endpackage

`default_nettype wire

### hw/rtl/actuator_select_step_pulse_driver.sv
// Step pulse driver for a motor board, fed one word at a time from a register
// bus front end. An input word is a millisecond tick, a bus write byte or a
// bus read request; every input word yields exactly one result word that shows
// the enables, step level, DC bridge pins, read data, busy and error flags.
// Input channel: in_valid_i, in_word_i, in_stall_o. Output channel:
// out_valid_o, out_word_o, out_stall_i. A word moves at a rising edge where
// valid is high and stall is low.
// The accepting edge loads the input register with a word; the edge at which
// that word advances runs the state update and loads the result register.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its word, the input
// register fills behind it, and in_stall_o rises only once both are full.
// Reset clears both valid flags and puts the core in its idle state: all enables
// high, step low, bridge pins low, no pulses pending.
`default_nettype none

module actuator_select_step_pulse_driver #(
  parameter int NUM_ACTUATORS = asspd_pkg::NUM_ACTUATORS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire asspd_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output asspd_pkg::out_word_t      out_word_o
);
  import asspd_pkg::*;

  in_word_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_word_t out_q;
  logic      out_valid_q, out_valid_d;
  out_word_t result;
  logic      advance;
  logic      accept;

  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign accept     = in_valid_i & ~in_stall_o;

  asspd_core #(
    .NUM_ACTUATORS(NUM_ACTUATORS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .word_i  (in_q),
    .result_o(result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### hw/rtl/asspd_core.sv
`default_nettype none

module asspd_core #(
  parameter int NUM_ACTUATORS = asspd_pkg::NUM_ACTUATORS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire asspd_pkg::in_word_t  word_i,
  output asspd_pkg::out_word_t      result_o
);
  import asspd_pkg::*;

  logic [7:0] actuator_q, actuator_d;
  logic [7:0] direction_q, direction_d;
  logic [7:0] count_q, count_d;
  logic [7:0] half_q, half_d;
  logic [4:0] enable_q, enable_d;
  logic [7:0] pulses_q, pulses_d;
  logic [7:0] phase_q, phase_d;
  logic       step_q, step_d;
  logic [1:0] bridge_q, bridge_d;
  logic [7:0] read_data;
  logic       error;

  logic [7:0] eff_old;
  logic [7:0] eff_new;
  logic [7:0] pulses_m1;
  logic [7:0] act_m1;
  logic [7:0] act_onehot;
  logic       dc_on;

  assign eff_old    = (half_q == 8'd0) ? 8'd1 : half_q;
  assign eff_new    = (word_i.data == 8'd0) ? 8'd1 : word_i.data;
  assign pulses_m1  = pulses_q - 8'd1;
  assign act_m1     = actuator_q - 8'd1;
  assign act_onehot = 8'd1 << act_m1[2:0];
  assign dc_on      = (count_q != 8'd0);

  always_comb begin
    actuator_d  = actuator_q;
    direction_d = direction_q;
    count_d     = count_q;
    half_d      = half_q;
    enable_d    = enable_q;
    pulses_d    = pulses_q;
    phase_d     = phase_q;
    step_d      = step_q;
    bridge_d    = bridge_q;
    read_data   = 8'd0;
    error       = 1'b0;
    case (word_i.op)
      OP_TICK: begin
        if (pulses_q != 8'd0) begin
          if (phase_q > 8'd1) begin
            phase_d = phase_q - 8'd1;
          end else if (step_q) begin
            step_d  = 1'b0;
            phase_d = eff_old;
          end else begin
            pulses_d = pulses_m1;
            if (pulses_m1 != 8'd0) begin
              step_d  = 1'b1;
              phase_d = eff_old;
            end else begin
              phase_d = 8'd0;
            end
          end
        end
      end
      OP_WRITE: begin
        if (word_i.byte_pos inside {[POS_ACTUATOR:POS_PERIOD]}) begin
          if (pulses_q != 8'd0) begin
            error = 1'b1;
          end else begin
            case (word_i.byte_pos)
              POS_ACTUATOR:  actuator_d  = word_i.data;
              POS_DIRECTION: direction_d = word_i.data;
              POS_COUNT:     count_d     = word_i.data;
              POS_PERIOD: begin
                half_d = word_i.data;
                if (actuator_q > 8'(NUM_ACTUATORS)) begin
                  error = 1'b1;
                end else if (actuator_q == 8'd0) begin
                  enable_d = ALL_OFF;
                  bridge_d = (direction_q == DIR_IN1) ? {1'b0, dc_on} : {dc_on, 1'b0};
                end else begin
                  enable_d = ALL_OFF & ~act_onehot[4:0];
                  pulses_d = count_q;
                  if (count_q != 8'd0) begin
                    step_d  = 1'b1;
                    phase_d = eff_new;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_READ: read_data = actuator_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      actuator_q  <= 8'd0;
      direction_q <= 8'd0;
      count_q     <= 8'd0;
      half_q      <= 8'd0;
      enable_q    <= ALL_OFF;
      pulses_q    <= 8'd0;
      phase_q     <= 8'd0;
      step_q      <= 1'b0;
      bridge_q    <= 2'b00;
    end else if (step_i) begin
      actuator_q  <= actuator_d;
      direction_q <= direction_d;
      count_q     <= count_d;
      half_q      <= half_d;
      enable_q    <= enable_d;
      pulses_q    <= pulses_d;
      phase_q     <= phase_d;
      step_q      <= step_d;
      bridge_q    <= bridge_d;
    end
  end

  assign result_o.enable_lines = enable_d;
  assign result_o.step_level   = step_d;
  assign result_o.dc_in1       = bridge_d[0];
  assign result_o.dc_in2       = bridge_d[1];
  assign result_o.read_data    = read_data;
  assign result_o.busy_res     = (pulses_d != 8'd0);
  assign result_o.error        = error;

endmodule

`default_nettype wire

### hw/rtl/asspd_checker.sv
`default_nettype none

module asspd_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire asspd_pkg::in_word_t  in_word_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire asspd_pkg::out_word_t out_word_o
);
  import asspd_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("Input word changed while stalled.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Result word dropped while stalled.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("Result word changed while stalled.");

  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.busy_res |-> !out_word_o.step_level)
    else $error("Step output high with no pulses pending.");

  a_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.dc_in1 && out_word_o.dc_in2))
    else $error("Both DC bridge inputs driven high.");

endmodule

bind actuator_select_step_pulse_driver asspd_checker u_asspd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_word_i  (in_word_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

`default_nettype wire
